/* src/fpba_pkg.sv */
`timescale 1ns / 1ps
package fpba_pkg;
  localparam int ADDR_BITS = 24;
  localparam int FIELD_W = 24;
  localparam int REGION_W = 25;
  localparam int STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;

  localparam logic CFG_REGION = 1'b0;
  localparam logic CFG_POLICY = 1'b1;

  localparam logic [1:0] POL_BEST = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic KIND_FREE = 1'b1;
endpackage

/* src/fit_policy_block_allocator.sv */
`timescale 1ns / 1ps
// allocate walks the free list, then on a split searches for a spare descriptor and
// writes the spare, the picked block and, if it has one, the previous link in the table;
// free scans the descriptors for the address and for the next neighbor, then walks
// the free list to unlink a merged neighbor and to find the previous neighbor
// throughput: one item at a time; a new item is accepted only in the idle state
// reset: synchronous active low; table holds one free block, totals zero
module fit_policy_block_allocator #(
  parameter int MAX_BLOCKS = 64,
  parameter int HEADER_BYTES = 32,
  parameter int PAGE_BYTES = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [47:0] in_tdata,   // request_bytes, free_address
  input  logic in_tuser,          // kind
  output logic out_tvalid,
  input  logic out_tready,
  output logic [95:0] out_tdata,  // payload_address, block_bytes, allocated_total, overhead_total
  output logic [2:0] out_tuser,   // status
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [fpba_pkg::REGION_W-1:0] cfg_wdata
);
  import fpba_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int LW = $clog2(MAX_BLOCKS + 1);
  localparam logic [LW-1:0] LEND = LW'(MAX_BLOCKS);
  localparam logic [25:0] HB = 26'(HEADER_BYTES);
  localparam logic [25:0] PG = 26'(PAGE_BYTES);
  localparam logic [25:0] TOP = 26'(1) << ADDR_BITS;
  localparam logic [REGION_W-1:0] RESET_REGION = 25'd65536;

  typedef enum logic [18:0] {
    S_IDLE  = 19'(1) << 0,
    S_A_RD  = 19'(1) << 1,
    S_A_CHK = 19'(1) << 2,
    S_A_DEC = 19'(1) << 3,
    S_A_SPR = 19'(1) << 4,
    S_A_WSP = 19'(1) << 5,
    S_A_WB  = 19'(1) << 6,
    S_A_WPV = 19'(1) << 7,
    S_F_RD  = 19'(1) << 8,
    S_F_CHK = 19'(1) << 9,
    S_N_BEG = 19'(1) << 10,
    S_N_RD  = 19'(1) << 11,
    S_N_CHK = 19'(1) << 12,
    S_U_RD  = 19'(1) << 13,
    S_U_CHK = 19'(1) << 14,
    S_P_BEG = 19'(1) << 15,
    S_P_RD  = 19'(1) << 16,
    S_P_CHK = 19'(1) << 17,
    S_FIN   = 19'(1) << 18
  } state_t;

  logic [FIELD_W-1:0] start_mem [MAX_BLOCKS];
  logic [FIELD_W-1:0] len_mem [MAX_BLOCKS];
  logic [LW-1:0] link_mem [MAX_BLOCKS];
  logic [FIELD_W-1:0] rd_start, rd_len;
  logic [LW-1:0] rd_link;
  logic [IW-1:0] raddr;

  logic st_we, ln_we, lk_we;
  logic [IW-1:0] st_wa, ln_wa, lk_wa;
  logic [FIELD_W-1:0] st_wd, ln_wd;
  logic [LW-1:0] lk_wd;

  state_t state_r, state_nxt;
  logic [LW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, cnt_r, cnt_nxt;
  logic [LW-1:0] pick_r, pick_nxt, pick_prev_r, pick_prev_nxt, pick_link_r, pick_link_nxt;
  logic [FIELD_W-1:0] pick_start_r, pick_start_nxt, pick_len_r, pick_len_nxt;
  logic [24:0] slack_r, slack_nxt, want_r, want_nxt;
  logic [FIELD_W-1:0] addr_r, addr_nxt;
  logic [IW-1:0] b_r, b_nxt;
  logic [FIELD_W-1:0] b_start_r, b_start_nxt, b_len_r, b_len_nxt;
  logic [LW-1:0] b_link_r, b_link_nxt, i_r, i_nxt, i_link_r, i_link_nxt;
  logic [25:0] nxt_r, nxt_nxt;
  logic [LW-1:0] head_r, head_nxt;
  logic [FIELD_W-1:0] asum_r, asum_nxt, hsum_r, hsum_nxt;
  logic [MAX_BLOCKS-1:0] in_use_r, in_use_nxt, free_r, free_nxt;
  logic [STATUS_W-1:0] res_st_r, res_st_nxt;
  logic [FIELD_W-1:0] res_pay_r, res_pay_nxt, res_len_r, res_len_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [95:0] out_data_r, out_data_nxt;
  logic [2:0] out_st_r, out_st_nxt;
  logic [1:0] fit_r;
  logic [24:0] region_end_r;

  logic init_go;
  logic [REGION_W-1:0] init_val;
  logic [25:0] rnd, rclamp;
  logic [24:0] len25, diff25;

  assign init_go = !rst_n || (cfg_we && cfg_index == CFG_REGION);
  assign init_val = !rst_n ? RESET_REGION : cfg_wdata;
  always_comb begin
    rnd = ({1'b0, init_val} + PG - 26'd1) & ~(PG - 26'd1);
    rclamp = rnd;
    if (rnd < PG) rclamp = PG;
    if (rnd > TOP) rclamp = TOP;
  end

  always_ff @(posedge clk) begin
    rd_start <= start_mem[raddr];
    rd_len <= len_mem[raddr];
    rd_link <= link_mem[raddr];
    if (init_go) begin
      start_mem[0] <= '0;
      len_mem[0] <= FIELD_W'(rclamp - HB);
      link_mem[0] <= LEND;
    end else begin
      if (st_we) start_mem[st_wa] <= st_wd;
      if (ln_we) len_mem[ln_wa] <= ln_wd;
      if (lk_we) link_mem[lk_wa] <= lk_wd;
    end
  end

  assign len25 = {1'b0, rd_len};
  assign diff25 = len25 - want_r;

  always_comb begin
    state_nxt = state_r;
    cur_nxt = cur_r; prev_nxt = prev_r; cnt_nxt = cnt_r;
    pick_nxt = pick_r; pick_prev_nxt = pick_prev_r; pick_link_nxt = pick_link_r;
    pick_start_nxt = pick_start_r; pick_len_nxt = pick_len_r;
    slack_nxt = slack_r; want_nxt = want_r; addr_nxt = addr_r;
    b_nxt = b_r; b_start_nxt = b_start_r; b_len_nxt = b_len_r; b_link_nxt = b_link_r;
    i_nxt = i_r; i_link_nxt = i_link_r; nxt_nxt = nxt_r;
    head_nxt = head_r; asum_nxt = asum_r; hsum_nxt = hsum_r;
    in_use_nxt = in_use_r; free_nxt = free_r;
    res_st_nxt = res_st_r; res_pay_nxt = res_pay_r; res_len_nxt = res_len_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r; out_st_nxt = out_st_r;
    raddr = '0;
    st_we = 1'b0; st_wa = '0; st_wd = '0;
    ln_we = 1'b0; ln_wa = '0; ln_wd = '0;
    lk_we = 1'b0; lk_wa = '0; lk_wd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_pay_nxt = '0;
          res_len_nxt = '0;
          res_st_nxt = ST_OK;
          if (in_tuser == KIND_FREE) begin
            addr_nxt = in_tdata[47:24];
            cnt_nxt = '0;
            if (in_tdata[47:24] == '0) begin
              res_st_nxt = ST_NULL;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_F_RD;
            end
          end else begin
            want_nxt = ({1'b0, in_tdata[23:0]} + 25'd3) & ~25'd3;
            cur_nxt = head_r;
            prev_nxt = LEND;
            pick_nxt = LEND;
            state_nxt = S_A_RD;
          end
        end
      end
      S_A_RD: begin
        raddr = cur_r[IW-1:0];
        state_nxt = (cur_r == LEND) ? S_A_DEC : S_A_CHK;
      end
      S_A_CHK: begin
        prev_nxt = cur_r;
        cur_nxt = rd_link;
        state_nxt = S_A_RD;
        if (len25 >= want_r) begin
          if ((fit_r != POL_BEST && fit_r != POL_WORST) || pick_r == LEND ||
              (fit_r == POL_BEST && diff25 < slack_r) ||
              (fit_r == POL_WORST && diff25 > slack_r)) begin
            pick_nxt = cur_r;
            pick_prev_nxt = prev_r;
            pick_start_nxt = rd_start;
            pick_len_nxt = rd_len;
            pick_link_nxt = rd_link;
            slack_nxt = diff25;
          end
          if (fit_r != POL_BEST && fit_r != POL_WORST) state_nxt = S_A_DEC;
        end
      end
      S_A_DEC: begin
        cnt_nxt = '0;
        if (pick_r == LEND) begin
          res_st_nxt = ST_NO_FIT;
          state_nxt = S_FIN;
        end else if ({2'b0, pick_len_r} >= {1'b0, want_r} + HB + 26'd4) begin
          state_nxt = S_A_SPR;
        end else begin
          state_nxt = S_A_WB;
        end
      end
      S_A_SPR: begin
        if (cnt_r == LEND) begin
          res_st_nxt = ST_FULL;
          state_nxt = S_FIN;
        end else if (!in_use_r[cnt_r[IW-1:0]]) begin
          state_nxt = S_A_WSP;
        end else begin
          cnt_nxt = cnt_r + LW'(1);
        end
      end
      S_A_WSP: begin
        in_use_nxt[cnt_r[IW-1:0]] = 1'b1;
        free_nxt[cnt_r[IW-1:0]] = 1'b1;
        st_we = 1'b1; st_wa = cnt_r[IW-1:0];
        st_wd = FIELD_W'({2'b0, pick_start_r} + HB + {1'b0, want_r});
        ln_we = 1'b1; ln_wa = cnt_r[IW-1:0];
        ln_wd = FIELD_W'({2'b0, pick_len_r} - {1'b0, want_r} - HB);
        lk_we = 1'b1; lk_wa = cnt_r[IW-1:0]; lk_wd = pick_link_r;
        pick_link_nxt = cnt_r;
        pick_len_nxt = FIELD_W'(want_r);
        state_nxt = S_A_WB;
      end
      S_A_WB: begin
        free_nxt[pick_r[IW-1:0]] = 1'b0;
        ln_we = 1'b1; ln_wa = pick_r[IW-1:0]; ln_wd = pick_len_r;
        lk_we = 1'b1; lk_wa = pick_r[IW-1:0]; lk_wd = LEND;
        asum_nxt = asum_r + pick_len_r;
        hsum_nxt = hsum_r + FIELD_W'(HB);
        res_pay_nxt = FIELD_W'({2'b0, pick_start_r} + HB);
        res_len_nxt = pick_len_r;
        if (pick_prev_r == LEND) begin
          head_nxt = pick_link_r;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_A_WPV;
        end
      end
      S_A_WPV: begin
        lk_we = 1'b1; lk_wa = pick_prev_r[IW-1:0]; lk_wd = pick_link_r;
        state_nxt = S_FIN;
      end
      S_F_RD: begin
        raddr = cnt_r[IW-1:0];
        if (cnt_r == LEND) begin
          res_st_nxt = ST_BAD_FREE;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (in_use_r[cnt_r[IW-1:0]] && !free_r[cnt_r[IW-1:0]] &&
            {2'b0, rd_start} + HB == {2'b0, addr_r}) begin
          b_nxt = cnt_r[IW-1:0];
          b_start_nxt = rd_start;
          b_len_nxt = rd_len;
          b_link_nxt = head_r;
          free_nxt[cnt_r[IW-1:0]] = 1'b1;
          lk_we = 1'b1; lk_wa = cnt_r[IW-1:0]; lk_wd = head_r;
          head_nxt = cnt_r;
          asum_nxt = asum_r - rd_len;
          hsum_nxt = hsum_r - FIELD_W'(HB);
          res_len_nxt = rd_len;
          state_nxt = S_N_BEG;
        end else begin
          cnt_nxt = cnt_r + LW'(1);
          state_nxt = S_F_RD;
        end
      end
      S_N_BEG: begin
        nxt_nxt = {2'b0, b_start_r} + HB + {2'b0, b_len_r};
        cnt_nxt = '0;
        state_nxt = ({2'b0, b_start_r} + HB + {2'b0, b_len_r} < {1'b0, region_end_r}) ?
                    S_N_RD : S_P_BEG;
      end
      S_N_RD: begin
        raddr = cnt_r[IW-1:0];
        state_nxt = (cnt_r == LEND) ? S_P_BEG : S_N_CHK;
      end
      S_N_CHK: begin
        if (cnt_r[IW-1:0] != b_r && in_use_r[cnt_r[IW-1:0]] && free_r[cnt_r[IW-1:0]] &&
            {2'b0, rd_start} == nxt_r) begin
          b_len_nxt = FIELD_W'({2'b0, b_len_r} + HB + {2'b0, rd_len});
          ln_we = 1'b1; ln_wa = b_r;
          ln_wd = FIELD_W'({2'b0, b_len_r} + HB + {2'b0, rd_len});
          i_nxt = cnt_r;
          i_link_nxt = rd_link;
          in_use_nxt[cnt_r[IW-1:0]] = 1'b0;
          free_nxt[cnt_r[IW-1:0]] = 1'b0;
          cur_nxt = head_r;
          prev_nxt = LEND;
          state_nxt = S_U_RD;
        end else begin
          cnt_nxt = cnt_r + LW'(1);
          state_nxt = S_N_RD;
        end
      end
      S_U_RD: begin
        raddr = cur_r[IW-1:0];
        if (cur_r == LEND) begin
          state_nxt = S_P_BEG;
        end else if (cur_r == i_r) begin
          if (prev_r == LEND) begin
            head_nxt = i_link_r;
          end else begin
            lk_we = 1'b1; lk_wa = prev_r[IW-1:0]; lk_wd = i_link_r;
            if (prev_r[IW-1:0] == b_r) b_link_nxt = i_link_r;
          end
          state_nxt = S_P_BEG;
        end else begin
          state_nxt = S_U_CHK;
        end
      end
      S_U_CHK: begin
        prev_nxt = cur_r;
        cur_nxt = rd_link;
        state_nxt = S_U_RD;
      end
      S_P_BEG: begin
        cur_nxt = head_r;
        state_nxt = S_P_RD;
      end
      S_P_RD: begin
        raddr = cur_r[IW-1:0];
        state_nxt = (cur_r == LEND) ? S_FIN : S_P_CHK;
      end
      S_P_CHK: begin
        if (cur_r[IW-1:0] != b_r &&
            {2'b0, rd_start} + HB + {2'b0, rd_len} == {2'b0, b_start_r}) begin
          ln_we = 1'b1; ln_wa = cur_r[IW-1:0];
          ln_wd = FIELD_W'({2'b0, rd_len} + HB + {2'b0, b_len_r});
          head_nxt = b_link_r;
          in_use_nxt[b_r] = 1'b0;
          free_nxt[b_r] = 1'b0;
          state_nxt = S_FIN;
        end else begin
          cur_nxt = rd_link;
          state_nxt = S_P_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt = res_st_r;
          out_data_nxt = {hsum_r, asum_r, res_len_r, res_pay_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      fit_r <= 2'd0;
      region_end_r <= 25'(rclamp);
      head_r <= '0;
      asum_r <= '0;
      hsum_r <= '0;
      in_use_r <= MAX_BLOCKS'(1);
      free_r <= MAX_BLOCKS'(1);
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_POLICY) fit_r <= cfg_wdata[1:0];
      if (init_go) begin
        region_end_r <= 25'(rclamp);
        head_r <= '0;
        asum_r <= '0;
        hsum_r <= '0;
        in_use_r <= MAX_BLOCKS'(1);
        free_r <= MAX_BLOCKS'(1);
      end else begin
        head_r <= head_nxt;
        asum_r <= asum_nxt;
        hsum_r <= hsum_nxt;
        in_use_r <= in_use_nxt;
        free_r <= free_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; prev_r <= prev_nxt; cnt_r <= cnt_nxt;
    pick_r <= pick_nxt; pick_prev_r <= pick_prev_nxt; pick_link_r <= pick_link_nxt;
    pick_start_r <= pick_start_nxt; pick_len_r <= pick_len_nxt;
    slack_r <= slack_nxt; want_r <= want_nxt; addr_r <= addr_nxt;
    b_r <= b_nxt; b_start_r <= b_start_nxt; b_len_r <= b_len_nxt; b_link_r <= b_link_nxt;
    i_r <= i_nxt; i_link_r <= i_link_nxt; nxt_r <= nxt_nxt;
    res_st_r <= res_st_nxt; res_pay_r <= res_pay_nxt; res_len_r <= res_len_nxt;
    out_data_r <= out_data_nxt; out_st_r <= out_st_nxt;
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_st_r;
endmodule

/* src/fpba_checker.sv */
`timescale 1ns / 1ps
module fpba_props (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic [2:0] out_tuser,
  input logic out_tvalid,
  input logic out_tready,
  input logic [95:0] out_tdata
);
  import fpba_pkg::*;

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_NO_FIT ||
                    out_tuser == ST_BAD_FREE || out_tuser == ST_NULL || out_tuser == ST_FULL))
    else $error("status out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata[47:0] == '0))
    else $error("failed transfer carries address or size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready right after an accepted transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");
endmodule

bind fit_policy_block_allocator fpba_props u_fpba_props (
  .clk(clk),
  .rst_n(rst_n),
  .in_tvalid(in_tvalid),
  .in_tready(in_tready),
  .out_tuser(out_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata)
);

/* tb/sv/fpba_checker.sv */
`timescale 1ns / 1ps
module fpba_checker #(
  parameter int MAX_BLOCKS = 64,
  parameter int HEADER_BYTES = 32,
  parameter int PAGE_BYTES = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tready,
  input  logic [47:0] in_tdata,   // request_bytes, free_address
  input  logic in_tuser,          // kind
  input  logic out_tvalid,
  input  logic out_tready,
  input  logic [95:0] out_tdata,  // payload_address, block_bytes, allocated_total, overhead_total
  input  logic [2:0] out_tuser,   // status
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [fpba_pkg::REGION_W-1:0] cfg_wdata,
  output int mismatches,
  output int outstanding,
  output int results_seen
);
  import fpba_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0] payload;
    logic [FIELD_W-1:0] bytes;
    logic [FIELD_W-1:0] alloc_sum;
    logic [FIELD_W-1:0] hdr_sum;
  } alloc_result_t;

  localparam int LIST_END = MAX_BLOCKS;

  alloc_result_t expected_results[$];

  logic [REGION_W-1:0] region_req;
  logic [1:0] policy;
  longint region_end;
  longint bstart[MAX_BLOCKS];
  longint blen[MAX_BLOCKS];
  bit bfree[MAX_BLOCKS];
  bit bused[MAX_BLOCKS];
  int flink[MAX_BLOCKS];
  int fhead;
  logic [FIELD_W-1:0] alloc_sum;
  logic [FIELD_W-1:0] hdr_sum;

  function automatic void table_init();
    longint r;
    r = ((longint'(region_req) + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
    if (r < PAGE_BYTES) r = PAGE_BYTES;
    if (r > (longint'(1) << ADDR_BITS)) r = longint'(1) << ADDR_BITS;
    region_end = r;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      bstart[i] = 0; blen[i] = 0; bfree[i] = 0; bused[i] = 0; flink[i] = LIST_END;
    end
    blen[0] = r - HEADER_BYTES;
    bfree[0] = 1;
    bused[0] = 1;
    fhead = 0;
    alloc_sum = '0;
    hdr_sum = '0;
  endfunction

  function automatic void unlink(int idx);
    int prev, cur;
    prev = LIST_END;
    cur = fhead;
    for (int n = 0; n <= MAX_BLOCKS && cur < MAX_BLOCKS; n++) begin
      if (cur == idx) begin
        if (prev == LIST_END) fhead = flink[cur];
        else flink[prev] = flink[cur];
        flink[cur] = LIST_END;
        return;
      end
      prev = cur;
      cur = flink[cur];
    end
  endfunction

  function automatic int find_fit(longint want);
    int pick, cur;
    longint slack, d;
    pick = LIST_END;
    cur = fhead;
    slack = 0;
    for (int n = 0; n <= MAX_BLOCKS && cur < MAX_BLOCKS; n++) begin
      if (blen[cur] >= want) begin
        d = blen[cur] - want;
        if (policy == POL_BEST) begin
          if (pick == LIST_END || d < slack) begin pick = cur; slack = d; end
        end else if (policy == POL_WORST) begin
          if (pick == LIST_END || d > slack) begin pick = cur; slack = d; end
        end else begin
          return cur;
        end
      end
      cur = flink[cur];
    end
    return pick;
  endfunction

  function automatic alloc_result_t predict_alloc(logic [FIELD_W-1:0] req);
    alloc_result_t res;
    longint want;
    int b, spare;
    res = '0;
    want = (longint'(req) + 3) & ~longint'(3);
    b = find_fit(want);
    if (b >= MAX_BLOCKS) begin
      res.status = ST_NO_FIT;
    end else begin
      res.status = ST_OK;
      if (blen[b] >= want + HEADER_BYTES + 4) begin
        spare = LIST_END;
        for (int i = 0; i < MAX_BLOCKS; i++)
          if (!bused[i] && spare == LIST_END) spare = i;
        if (spare == LIST_END) begin
          res.status = ST_FULL;
        end else begin
          bused[spare] = 1;
          bfree[spare] = 1;
          bstart[spare] = bstart[b] + HEADER_BYTES + want;
          blen[spare] = blen[b] - want - HEADER_BYTES;
          flink[spare] = flink[b];
          flink[b] = spare;
          blen[b] = want;
        end
      end
      if (res.status == ST_OK) begin
        unlink(b);
        bfree[b] = 0;
        alloc_sum = alloc_sum + blen[b][FIELD_W-1:0];
        hdr_sum = hdr_sum + FIELD_W'(HEADER_BYTES);
        res.payload = FIELD_W'(bstart[b] + HEADER_BYTES);
        res.bytes = blen[b][FIELD_W-1:0];
      end
    end
    res.alloc_sum = alloc_sum;
    res.hdr_sum = hdr_sum;
    return res;
  endfunction

  function automatic alloc_result_t predict_free(logic [FIELD_W-1:0] addr);
    alloc_result_t res;
    int b, cur;
    longint nxt;
    bit merged;
    res = '0;
    b = LIST_END;
    if (addr == 0) begin
      res.status = ST_NULL;
    end else begin
      for (int i = 0; i < MAX_BLOCKS; i++)
        if (b == LIST_END && bused[i] && !bfree[i] && bstart[i] + HEADER_BYTES == addr) b = i;
      if (b == LIST_END) begin
        res.status = ST_BAD_FREE;
      end else begin
        res.status = ST_OK;
        bfree[b] = 1;
        flink[b] = fhead;
        fhead = b;
        res.bytes = blen[b][FIELD_W-1:0];
        alloc_sum = alloc_sum - blen[b][FIELD_W-1:0];
        hdr_sum = hdr_sum - FIELD_W'(HEADER_BYTES);
        nxt = bstart[b] + HEADER_BYTES + blen[b];
        merged = 0;
        if (nxt < region_end) begin
          for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (!merged && i != b && bused[i] && bfree[i] && bstart[i] == nxt) begin
              blen[b] = blen[b] + HEADER_BYTES + blen[i];
              unlink(i);
              bused[i] = 0; bfree[i] = 0; bstart[i] = 0; blen[i] = 0;
              merged = 1;
            end
          end
        end
        cur = fhead;
        for (int n = 0; n <= MAX_BLOCKS && cur < MAX_BLOCKS; n++) begin
          if (cur != b && bstart[cur] + HEADER_BYTES + blen[cur] == bstart[b]) begin
            blen[cur] = blen[cur] + HEADER_BYTES + blen[b];
            unlink(b);
            bused[b] = 0; bfree[b] = 0; bstart[b] = 0; blen[b] = 0;
            break;
          end
          cur = flink[cur];
        end
      end
    end
    res.alloc_sum = alloc_sum;
    res.hdr_sum = hdr_sum;
    return res;
  endfunction

  task automatic report(string what, logic [FIELD_W-1:0] exp_v, logic [FIELD_W-1:0] act_v);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
  endtask

  initial begin
    mismatches = 0;
    results_seen = 0;
  end

  assign outstanding = expected_results.size();

  always @(posedge clk) begin
    alloc_result_t want_r;
    alloc_result_t got;
    if (!rst_n) begin
      region_req = REGION_W'(65536);
      policy = 2'd0;
      table_init();
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_REGION) begin
          region_req = cfg_wdata;
          table_init();
        end else begin
          policy = cfg_wdata[1:0];
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == KIND_FREE) expected_results.push_back(predict_free(in_tdata[47:24]));
        else expected_results.push_back(predict_alloc(in_tdata[23:0]));
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.status = out_tuser;
        got.payload = out_tdata[23:0];
        got.bytes = out_tdata[47:24];
        got.alloc_sum = out_tdata[71:48];
        got.hdr_sum = out_tdata[95:72];
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result transfer, actual status %0d", $time, got.status);
        end else begin
          want_r = expected_results.pop_front();
          if (got.status !== want_r.status) report("status", want_r.status, got.status);
          if (got.payload !== want_r.payload) report("payload_address", want_r.payload, got.payload);
          if (got.bytes !== want_r.bytes) report("block_bytes", want_r.bytes, got.bytes);
          if (got.alloc_sum !== want_r.alloc_sum)
            report("allocated_total", want_r.alloc_sum, got.alloc_sum);
          if (got.hdr_sum !== want_r.hdr_sum)
            report("overhead_total", want_r.hdr_sum, got.hdr_sum);
        end
      end
    end
  end
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import fpba_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [95:0] out_tdata;
  logic [2:0] out_tuser;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [REGION_W-1:0] cfg_wdata = '0;

  int mismatches, outstanding, results_seen;
  int items_sent = 0;
  int phases_done = 0;
  logic [FIELD_W-1:0] live_payloads[$];

  fit_policy_block_allocator dut (.*);

  fpba_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .outstanding(outstanding), .results_seen(results_seen)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    #100_000_000;
    $display("timeout after %0d results", results_seen);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // receiver: random stalls, one long hold once the run is under way
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (!hold_done && results_seen >= 60) begin
      hold_done <= 1;
      hold_left <= 3000;
      out_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 0;
    end else if (phases_done == 2) begin
      out_tready <= 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 199) == 0) hold_left <= $urandom_range(20, 150);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && out_tuser == ST_OK && out_tdata[23:0] != 0)
      live_payloads.push_back(out_tdata[23:0]);
  end

  task automatic send(logic kind, logic [FIELD_W-1:0] req, logic [FIELD_W-1:0] addr);
    int gap;
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= {addr, req};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    gap = (phases_done == 2) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic idx, logic [REGION_W-1:0] val);
    in_tvalid <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    live_payloads.delete();
    @(posedge clk);
  endtask

  task automatic random_item();
    int r, k;
    logic [FIELD_W-1:0] sz;
    r = $urandom_range(0, 99);
    if (r < 52) begin
      k = $urandom_range(0, 99);
      if (k < 80) sz = FIELD_W'($urandom_range(0, 200));
      else if (k < 95) sz = FIELD_W'($urandom_range(0, 8192));
      else sz = FIELD_W'($urandom());
      send(1'b0, sz, FIELD_W'($urandom()));
    end else if (r < 88 && live_payloads.size() > 0) begin
      k = $urandom_range(0, live_payloads.size() - 1);
      sz = live_payloads[k];
      live_payloads.delete(k);
      send(KIND_FREE, FIELD_W'($urandom()), sz);
    end else if (r < 93 && live_payloads.size() > 0) begin
      sz = live_payloads[$urandom_range(0, live_payloads.size() - 1)] + FIELD_W'(4);
      send(KIND_FREE, FIELD_W'($urandom()), sz);
    end else if (r < 98) begin
      send(KIND_FREE, FIELD_W'($urandom()), FIELD_W'($urandom()));
    end else begin
      send(KIND_FREE, FIELD_W'($urandom()), 24'd0);
    end
  endtask

  initial begin
    logic [REGION_W-1:0] regions[6];
    logic [1:0] policies[6];
    regions = '{25'd65536, 25'd4096, 25'h1FFFFFF, 25'd0, 25'd16777216, 25'd70000};
    policies = '{2'd0, POL_BEST, POL_WORST, 2'd3, POL_BEST, POL_WORST};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, null and invalid frees, zero and huge requests
    send(1'b0, 24'd0, 24'd0);
    send(1'b0, 24'd1, 24'hFFFFFF);
    send(1'b0, 24'hFFFFFF, 24'd0);
    send(1'b0, 24'd61000, 24'd0);
    send(KIND_FREE, 24'd0, 24'd0);
    send(KIND_FREE, 24'hFFFFFF, 24'hFFFFFF);
    send(KIND_FREE, 24'hFFFFFF, 24'd32);
    send(KIND_FREE, 24'd0, 24'd32);
    send(1'b0, 24'd5, 24'd0);
    send(1'b0, 24'd7, 24'd0);
    send(1'b0, 24'd8, 24'd0);
    send(KIND_FREE, 24'd0, 24'd68);
    send(KIND_FREE, 24'd0, 24'd108);
    send(KIND_FREE, 24'd0, 24'd140);
    for (int i = 0; i < 66; i++) send(1'b0, 24'd4, 24'd0);
    for (int i = 0; i < 10; i++) send(KIND_FREE, 24'd0, 24'(32 + 36 * i));

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_POLICY, {23'd0, policies[p]});
      if (p > 0) write_reg(CFG_REGION, regions[p]);
      if (p == 5) phases_done = 2;
      for (int i = 0; i < 290; i++) random_item();
    end

    in_tvalid <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("sent %0d items, checked %0d results", items_sent, results_seen);
    $display("six region and policy settings, extremes included, with stalls on both sides");
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
